FILE: sv/ber_tlv_primitive_encoder_unit_macros.svh
`ifndef BER_TLV_PRIMITIVE_ENCODER_UNIT_MACROS_SVH
`define BER_TLV_PRIMITIVE_ENCODER_UNIT_MACROS_SVH

// same-cycle implication
`define BERTLV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BERTLV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/bertlv_pkg.sv
`timescale 1ns / 1ps

package bertlv_pkg;

    localparam logic [2:0] KIND_SIGNED   = 3'd0;
    localparam logic [2:0] KIND_UNSIGNED = 3'd1;
    localparam logic [2:0] KIND_EMPTY    = 3'd2;
    localparam logic [2:0] KIND_HEADER   = 3'd3;
    localparam logic [2:0] KIND_RAW      = 3'd4;
    localparam logic [2:0] KIND_RESTART  = 3'd5;

    localparam logic [7:0]  INTEGER_TAG   = 8'h02;
    localparam logic [7:0]  LONG_LEN_FLAG = 8'h80;
    localparam logic [31:0] SHORT_LEN_MAX = 32'h0000_007F;
    localparam logic [15:0] BUF_SIZE_RST  = 16'd1024;

    localparam int MAX_BYTES = 7;

    typedef struct packed {
        logic [8*MAX_BYTES-1:0] bytes;   // first byte in the top octet
        logic [2:0]             count;
        logic                   emits;
    } t_enc;

endpackage

FILE: sv/bertlv_encode.sv
`timescale 1ns / 1ps

module bertlv_encode (
    input  logic [2:0]         i_kind,
    input  logic [7:0]         i_tag,
    input  logic [31:0]        i_value,
    input  logic [31:0]        i_content_length,
    input  logic [7:0]         i_data_byte,
    output bertlv_pkg::t_enc   o_enc
);

    logic [2:0]  s_n;
    logic [2:0]  u_n;
    logic [2:0]  c_n;
    logic [39:0] c_al;
    logic [2:0]  l_n;
    logic [31:0] l_al;
    logic [7:0]  c_tag;

    always_comb begin
        if ((i_value[31:7] == '0) || (i_value[31:7] == '1)) begin
            s_n = 3'd1;
        end else if ((i_value[31:15] == '0) || (i_value[31:15] == '1)) begin
            s_n = 3'd2;
        end else if ((i_value[31:23] == '0) || (i_value[31:23] == '1)) begin
            s_n = 3'd3;
        end else begin
            s_n = 3'd4;
        end

        if (i_value[31]) begin
            u_n = 3'd5;
        end else if (i_value[31:7] == '0) begin
            u_n = 3'd1;
        end else if (i_value[31:15] == '0) begin
            u_n = 3'd2;
        end else if (i_value[31:23] == '0) begin
            u_n = 3'd3;
        end else begin
            u_n = 3'd4;
        end

        c_n   = (i_kind == bertlv_pkg::KIND_SIGNED) ? s_n : u_n;
        c_tag = (i_kind == bertlv_pkg::KIND_SIGNED) ? bertlv_pkg::INTEGER_TAG : i_tag;

        case (c_n)
            3'd1:    c_al = {i_value[7:0], 32'h0};
            3'd2:    c_al = {i_value[15:0], 24'h0};
            3'd3:    c_al = {i_value[23:0], 16'h0};
            3'd4:    c_al = {i_value, 8'h0};
            default: c_al = {8'h00, i_value};
        endcase

        if (i_content_length[31:24] != '0) begin
            l_n = 3'd4;
        end else if (i_content_length[31:16] != '0) begin
            l_n = 3'd3;
        end else if (i_content_length[31:8] != '0) begin
            l_n = 3'd2;
        end else begin
            l_n = 3'd1;
        end

        case (l_n)
            3'd1:    l_al = {i_content_length[7:0], 24'h0};
            3'd2:    l_al = {i_content_length[15:0], 16'h0};
            3'd3:    l_al = {i_content_length[23:0], 8'h0};
            default: l_al = i_content_length;
        endcase

        o_enc = '0;
        case (i_kind)
            bertlv_pkg::KIND_SIGNED, bertlv_pkg::KIND_UNSIGNED: begin
                o_enc.bytes = {c_tag, {5'b0, c_n}, c_al};
                o_enc.count = c_n + 3'd2;
                o_enc.emits = 1'b1;
            end
            bertlv_pkg::KIND_EMPTY: begin
                o_enc.bytes = {i_tag, 48'h0};
                o_enc.count = 3'd2;
                o_enc.emits = 1'b1;
            end
            bertlv_pkg::KIND_HEADER: begin
                if (i_content_length <= bertlv_pkg::SHORT_LEN_MAX) begin
                    o_enc.bytes = {i_tag, i_content_length[7:0], 40'h0};
                    o_enc.count = 3'd2;
                end else begin
                    o_enc.bytes = {i_tag, bertlv_pkg::LONG_LEN_FLAG | {5'b0, l_n}, l_al, 8'h0};
                    o_enc.count = l_n + 3'd2;
                end
                o_enc.emits = 1'b1;
            end
            bertlv_pkg::KIND_RAW: begin
                o_enc.bytes = {i_data_byte, 48'h0};
                o_enc.count = 3'd1;
                o_enc.emits = 1'b1;
            end
            default: begin
                o_enc = '0;
            end
        endcase
    end

endmodule

FILE: sv/ber_tlv_primitive_encoder_unit.sv
`timescale 1ns / 1ps

// BER TLV encoder: each request is held in an input register, encoded in one
// pass and loaded into a byte shift register that hands out one byte per
// cycle while i_out_stall is low, tag first (raw gives only its data byte).
// A request gives 1 to 7 bytes, one for an overflow result; restart and
// unused kinds give no bytes. The output shift register sets the rate, and the
// next request waits in the input register while the current bytes drain.
// i_cfg_data sets what a restart restores; space is 1024 bytes after reset.

`include "ber_tlv_primitive_encoder_unit_macros.svh"

module ber_tlv_primitive_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_tag,
    input  logic [31:0] i_value,
    input  logic [31:0] i_content_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_status,
    output logic        o_last
);

    logic        r_in_valid;
    logic [2:0]  r_kind;
    logic [7:0]  r_tag;
    logic [31:0] r_value;
    logic [31:0] r_content_length;
    logic [7:0]  r_data_byte;

    logic [15:0] r_buf_size;
    logic [15:0] r_space_left;

    logic        r_b_valid;
    logic [55:0] r_b_bytes;
    logic [2:0]  r_b_cnt;
    logic        r_b_status;

    bertlv_pkg::t_enc enc;

    logic in_acc;
    logic out_acc;
    logic b_free;
    logic adv_in;
    logic load;
    logic ovf;

    bertlv_encode u_encode (
        .i_kind           (r_kind),
        .i_tag            (r_tag),
        .i_value          (r_value),
        .i_content_length (r_content_length),
        .i_data_byte      (r_data_byte),
        .o_enc            (enc)
    );

    assign out_acc    = r_b_valid && !i_out_stall;
    assign b_free     = !r_b_valid || (out_acc && (r_b_cnt == 3'd1));
    assign adv_in     = r_in_valid && (!enc.emits || b_free);
    assign load       = adv_in && enc.emits;
    assign ovf        = {13'b0, enc.count} > r_space_left;
    assign o_in_stall = r_in_valid && !adv_in;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_out_valid = r_b_valid;
    assign o_out_byte  = r_b_bytes[55:48];
    assign o_status    = r_b_status;
    assign o_last      = (r_b_cnt == 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_b_valid    <= 1'b0;
            r_b_cnt      <= '0;
            r_buf_size   <= bertlv_pkg::BUF_SIZE_RST;
            r_space_left <= bertlv_pkg::BUF_SIZE_RST;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv_in) begin
                r_in_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                r_buf_size <= i_cfg_data;
            end

            if (adv_in && (r_kind == bertlv_pkg::KIND_RESTART)) begin
                r_space_left <= r_buf_size;
            end else if (load && !ovf) begin
                r_space_left <= r_space_left - {13'b0, enc.count};
            end

            if (load) begin
                r_b_valid <= 1'b1;
                r_b_cnt   <= ovf ? 3'd1 : enc.count;
            end else if (out_acc) begin
                r_b_valid <= (r_b_cnt != 3'd1);
                r_b_cnt   <= r_b_cnt - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind           <= i_kind;
            r_tag            <= i_tag;
            r_value          <= i_value;
            r_content_length <= i_content_length;
            r_data_byte      <= i_data_byte;
        end
        if (load) begin
            r_b_bytes  <= ovf ? 56'h0 : enc.bytes;
            r_b_status <= ovf;
        end else if (out_acc) begin
            r_b_bytes <= {r_b_bytes[47:0], 8'h00};
        end
    end

    `BERTLV_ASSERT_IMP(a_ovf_single, i_clk, i_rst_n, o_out_valid && o_status, o_last)
    `BERTLV_ASSERT_NXT(a_ovf_load, i_clk, i_rst_n, load && ovf, o_out_valid && o_status && o_last)
    `BERTLV_ASSERT_NXT(a_space_used, i_clk, i_rst_n, load && !ovf, r_space_left == $past(r_space_left - {13'b0, enc.count}))
    `BERTLV_ASSERT_IMP(a_cnt_live, i_clk, i_rst_n, o_out_valid, r_b_cnt != 3'd0)

endmodule
